FILE: design/hlaf_pkg.sv
// shared types, constants and lookup functions for the local hostname filter
package hlaf_pkg;

    // result kinds
    typedef enum logic [1:0] {
        KIND_EMPTY = 2'd0,
        KIND_LOCAL = 2'd1,
        KIND_IPV4  = 2'd2,
        KIND_OTHER = 2'd3
    } t_kind;

    // per-word control from the input stage to the matchers
    typedef struct packed {
        logic step;   // a character of a name is consumed
        logic clear;  // the name ends, state returns to reset values
    } t_ctl;

    // ipv4 parser verdict on the name seen so far
    typedef struct packed {
        logic is_ipv4;
        logic allowed;
    } t_ip_res;

    localparam int SHORT_LEN = 9;
    localparam int LONG_LEN  = 21;
    localparam int TAIL_LEN  = 6;
    localparam int POS_MAX   = 31;

    localparam logic [8*LONG_LEN-1:0] LONG_TEXT = "localhost.localdomain";
    localparam logic [8*TAIL_LEN-1:0] TAIL_TEXT = ".local";

    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
    localparam logic [7:0] ASCII_CASE    = 8'h20;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_DOT     = 8'h2E;

    // character of localhost.localdomain at a position below LONG_LEN
    function automatic logic [7:0] long_char(input logic [4:0] pos);
        logic [7:0] ch;
        ch = 8'h00;
        for (int k = 0; k < LONG_LEN; k++) begin
            if (pos == 5'(k)) begin
                ch = LONG_TEXT[8*(LONG_LEN-1-k) +: 8];
            end
        end
        return ch;
    endfunction

    // character of .local at a tail position
    function automatic logic [7:0] tail_char(input int idx);
        return TAIL_TEXT[8*(TAIL_LEN-1-idx) +: 8];
    endfunction

    // ipv4 allow list
    function automatic logic ipv4_allowed(input logic [7:0] a, input logic [7:0] b,
                                          input logic [7:0] c, input logic [7:0] d);
        logic ok;
        ok = 1'b0;
        if (a == 8'd0 && b == 8'd0 && c == 8'd0 && d == 8'd0) ok = 1'b1;
        if (a == 8'd10 || a == 8'd25 || a == 8'd26 || a == 8'd127) ok = 1'b1;
        if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) ok = 1'b1;
        if (a == 8'd169 && b == 8'd254) ok = 1'b1;
        if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) ok = 1'b1;
        if (a == 8'd192 && b == 8'd168) ok = 1'b1;
        if (a >= 8'd224 && a <= 8'd239) ok = 1'b1;
        if (a == 8'd255 && b == 8'd255 && c == 8'd255 && d == 8'd255) ok = 1'b1;
        return ok;
    endfunction

endpackage

FILE: design/hlaf_match.sv
// name matcher: localhost, localhost.localdomain and the .local suffix
module hlaf_match #(
    parameter int CW = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  hlaf_pkg::t_ctl   i_ctl,
    input  logic [CW-1:0]    i_char,
    output logic             o_local
);
    import hlaf_pkg::*;

    logic [4:0]    r_pos, n_pos;
    logic          r_short, n_short;
    logic          r_long, n_long;
    logic [CW-1:0] r_tail [TAIL_LEN];
    logic [CW-1:0] n_tail [TAIL_LEN];
    logic [2:0]    r_fill, n_fill;
    logic [CW-1:0] lc;
    logic [CW-1:0] exp_ch;
    logic          tail_ok;

    // ascii case fold
    always_comb begin
        if (i_char >= CW'(ASCII_UPPER_A) && i_char <= CW'(ASCII_UPPER_Z)) begin
            lc = i_char + CW'(ASCII_CASE);
        end else begin
            lc = i_char;
        end
    end

    always_comb begin
        exp_ch  = CW'(long_char(r_pos));
        n_short = r_short && (r_pos < 5'(SHORT_LEN)) && (lc == exp_ch);
        n_long  = r_long && (r_pos < 5'(LONG_LEN)) && (lc == exp_ch);
        n_pos   = (r_pos == 5'(POS_MAX)) ? r_pos : r_pos + 5'd1;
        n_fill  = (r_fill == 3'(TAIL_LEN)) ? r_fill : r_fill + 3'd1;
        for (int k = 0; k < TAIL_LEN - 1; k++) begin
            n_tail[k] = r_tail[k+1];
        end
        n_tail[TAIL_LEN-1] = lc;
        tail_ok = 1'b1;
        for (int k = 0; k < TAIL_LEN; k++) begin
            if (n_tail[k] != CW'(tail_char(k))) tail_ok = 1'b0;
        end
        o_local = (n_short && n_pos == 5'(SHORT_LEN))
               || (n_long && n_pos == 5'(LONG_LEN))
               || (n_fill == 3'(TAIL_LEN) && tail_ok);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_pos   <= '0;
            r_short <= 1'b1;
            r_long  <= 1'b1;
            r_fill  <= '0;
        end else if (i_ctl.step) begin
            r_pos   <= n_pos;
            r_short <= n_short;
            r_long  <= n_long;
            r_fill  <= n_fill;
        end
    end

    // window content only counts once the fill count covers it
    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_tail <= n_tail;
        end
    end

endmodule

FILE: design/hlaf_ipv4.sv
// dotted-decimal ipv4 parser and allow list check
module hlaf_ipv4 #(
    parameter int CW = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  hlaf_pkg::t_ctl    i_ctl,
    input  logic [CW-1:0]     i_char,
    output hlaf_pkg::t_ip_res o_res
);
    import hlaf_pkg::*;

    logic [1:0]  r_index, n_index;
    logic [7:0]  r_accum, n_accum;
    logic [1:0]  r_digits, n_digits;
    logic        r_lead0, n_lead0;
    logic        r_broken, n_broken;
    logic [7:0]  r_store [3];
    logic        is_digit, is_dot, closes, n_closes, store_we;
    logic [3:0]  dval;
    logic [11:0] acc_val;

    always_comb begin
        is_digit = (i_char >= CW'(ASCII_ZERO)) && (i_char <= CW'(ASCII_NINE));
        is_dot   = (i_char == CW'(ASCII_DOT));
        dval     = i_char[3:0];
        acc_val  = 12'(r_accum) * 12'd10 + 12'(dval);
        closes   = (r_digits != 2'd0) && !(r_digits > 2'd1 && r_lead0);

        n_index  = r_index;
        n_accum  = r_accum;
        n_digits = r_digits;
        n_lead0  = r_lead0;
        n_broken = r_broken;
        store_we = 1'b0;
        if (!r_broken) begin
            if (is_digit) begin
                if (r_digits == 2'd3 || acc_val > 12'd255) begin
                    n_broken = 1'b1;
                end else begin
                    if (r_digits == 2'd0 && dval == 4'd0) n_lead0 = 1'b1;
                    n_accum  = acc_val[7:0];
                    n_digits = r_digits + 2'd1;
                end
            end else if (is_dot) begin
                if (r_index == 2'd3 || !closes) begin
                    n_broken = 1'b1;
                end else begin
                    store_we = 1'b1;
                    n_index  = r_index + 2'd1;
                    n_accum  = '0;
                    n_digits = '0;
                    n_lead0  = 1'b0;
                end
            end else begin
                n_broken = 1'b1;
            end
        end

        n_closes      = (n_digits != 2'd0) && !(n_digits > 2'd1 && n_lead0);
        o_res.is_ipv4 = !n_broken && n_index == 2'd3 && n_closes;
        o_res.allowed = ipv4_allowed(r_store[0], r_store[1], r_store[2], n_accum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_ctl.clear) begin
            r_index  <= '0;
            r_accum  <= '0;
            r_digits <= '0;
            r_lead0  <= 1'b0;
            r_broken <= 1'b0;
        end else if (i_ctl.step) begin
            r_index  <= n_index;
            r_accum  <= n_accum;
            r_digits <= n_digits;
            r_lead0  <= n_lead0;
            r_broken <= n_broken;
        end
    end

    // a dot writes only while fewer than three octets are done
    always_ff @(posedge i_clk) begin
        if (i_ctl.step && store_we) begin
            r_store[r_index] <= r_accum;
        end
    end

endmodule

FILE: design/hostname_local_address_filter_unit.sv
// top level of the local hostname filter
//
// usage:
//   a hostname enters one character per input word on the i_in_valid / o_in_ready
//   channel; i_is_last marks the final character, i_empty_name marks an empty
//   name and makes that word's character meaningless
//   one result word per name leaves on o_out_valid / i_out_ready with o_allowed
//   and o_name_kind (empty, local name, ipv4 literal, other text)
//   words that are not last and not empty give no result
// timing:
//   one input word per cycle while o_in_ready is high; each word is held in the input
//   register, then its result is registered in the output register when that
//   register is free or draining
//   matching is constant compares and one times-ten accumulate per character,
//   all between the input register and the name state / output register
// reset and stall:
//   synchronous active-low reset clears both valids and the per-name counters and flags;
//   a stalled result holds in the output register while the input register
//   still takes one more word, then o_in_ready drops until the output drains
module hostname_local_address_filter_unit #(
    parameter int CHAR_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [15:0] i_char_code,
    input  logic        i_is_last,
    input  logic        i_empty_name,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_allowed,
    output logic [1:0]  o_name_kind
);
    import hlaf_pkg::*;

    // usable code width: the port carries 16 bits, codes are cut to CHAR_BITS, at most 16
    localparam int CW = (CHAR_BITS < 16) ? CHAR_BITS : 16;

    // input register
    logic          r_in_valid;
    logic [CW-1:0] r_char;
    logic          r_last;
    logic          r_empty;

    // output register
    logic          r_out_valid;
    logic          r_allowed;
    t_kind         r_kind;

    logic          advance;
    logic          fire;
    logic          ends_name;
    t_ctl          ctl;
    logic          name_local;
    t_ip_res       ip_res;
    logic          n_allowed;
    t_kind         n_kind;

    // the processing stage moves whenever the output register is free or draining
    assign advance    = !r_out_valid || i_out_ready;
    assign o_in_ready = !r_in_valid || advance;
    assign fire       = r_in_valid && advance;
    assign ends_name  = r_empty || r_last;

    assign ctl.step  = fire && !r_empty;
    assign ctl.clear = fire && ends_name;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_char  <= i_char_code[CW-1:0];
            r_last  <= i_is_last;
            r_empty <= i_empty_name;
        end
    end

    hlaf_match #(
        .CW (CW)
    ) u_match (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_char  (r_char),
        .o_local (name_local)
    );

    hlaf_ipv4 #(
        .CW (CW)
    ) u_ipv4 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .i_char  (r_char),
        .o_res   (ip_res)
    );

    // verdict priority: empty, local name, ipv4 literal, other
    always_comb begin
        if (r_empty) begin
            n_allowed = 1'b1;
            n_kind    = KIND_EMPTY;
        end else if (name_local) begin
            n_allowed = 1'b1;
            n_kind    = KIND_LOCAL;
        end else if (ip_res.is_ipv4) begin
            n_allowed = ip_res.allowed;
            n_kind    = KIND_IPV4;
        end else begin
            n_allowed = 1'b0;
            n_kind    = KIND_OTHER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= fire && ends_name;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && fire && ends_name) begin
            r_allowed <= n_allowed;
            r_kind    <= n_kind;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_allowed   = r_allowed;
    assign o_name_kind = r_kind;

`ifndef SYNTH
    a_result_from_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_in_valid && (r_empty || r_last)))
        else $error("result word without a name end");

    a_empty_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_name_kind == KIND_EMPTY) |-> o_allowed)
        else $error("empty name not allowed");

    a_other_blocked: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_name_kind == KIND_OTHER) |-> !o_allowed)
        else $error("other text marked allowed");

    a_local_allowed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_name_kind == KIND_LOCAL) |-> o_allowed)
        else $error("local name not allowed");

    a_stall_keeps_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> r_in_valid)
        else $error("input word lost under stall");
`endif

endmodule

FILE: tb/hostname_verdict_pkg.sv
// scoreboard class that predicts the verdict of each hostname fed to the local hostname filter
`timescale 1ns / 100ps
package hostname_verdict_pkg;
    import hlaf_pkg::*;

    typedef struct packed {
        logic  allowed;
        t_kind kind;
    } t_verdict;

    localparam int NAME_LEN   = 9;
    localparam int DOMAIN_LEN = 21;
    localparam int SUFFIX_LEN = 6;
    localparam int POS_TOP    = 31;

    localparam logic [8*DOMAIN_LEN-1:0] LOOPBACK_TEXT = "localhost.localdomain";
    localparam logic [8*SUFFIX_LEN-1:0] SUFFIX_TEXT   = ".local";

    localparam logic [15:0] CH_ZERO    = 16'h0030;
    localparam logic [15:0] CH_NINE    = 16'h0039;
    localparam logic [15:0] CH_DOT     = 16'h002E;
    localparam logic [15:0] CH_UPPER_A = 16'h0041;
    localparam logic [15:0] CH_UPPER_Z = 16'h005A;
    localparam logic [15:0] CH_LOWER_A = 16'h0061;
    localparam logic [15:0] CH_LOWER_Z = 16'h007A;
    localparam logic [15:0] CASE_GAP   = 16'h0020;

    class hostname_verdict_board;
        t_verdict    pending_verdicts [$];
        int          mismatches;
        logic [4:0]  seen_count;
        logic        host_prefix_ok;
        logic        domain_prefix_ok;
        logic [15:0] last_six [SUFFIX_LEN];
        logic [2:0]  last_six_fill;
        logic [1:0]  dots_taken;
        logic [7:0]  octet_value;
        logic [1:0]  octet_digits;
        logic        octet_zero_led;
        logic        not_dotted_quad;
        logic [7:0]  done_octets [4];

        function new();
            mismatches = 0;
            foreach (done_octets[k]) done_octets[k] = 8'd0;
            start_name();
        endfunction

        function void start_name();
            seen_count       = 5'd0;
            host_prefix_ok   = 1'b1;
            domain_prefix_ok = 1'b1;
            foreach (last_six[k]) last_six[k] = 16'h0000;
            last_six_fill    = 3'd0;
            dots_taken       = 2'd0;
            octet_value      = 8'd0;
            octet_digits     = 2'd0;
            octet_zero_led   = 1'b0;
            not_dotted_quad  = 1'b0;
        endfunction

        function logic [15:0] loopback_char(int idx);
            return {8'h00, LOOPBACK_TEXT[8*(DOMAIN_LEN-1-idx) +: 8]};
        endfunction

        function logic [15:0] suffix_char(int idx);
            return {8'h00, SUFFIX_TEXT[8*(SUFFIX_LEN-1-idx) +: 8]};
        endfunction

        // an octet may end here: some digits, and no leading zero unless it is a lone zero
        function logic octet_complete();
            return octet_digits != 2'd0 && !(octet_digits > 2'd1 && octet_zero_led);
        endfunction

        function void parse_char(logic [15:0] c);
            int sum;
            if (not_dotted_quad) return;
            if (c >= CH_ZERO && c <= CH_NINE) begin
                sum = int'(octet_value) * 10 + int'(c - CH_ZERO);
                if (octet_digits == 2'd3 || sum > 255) begin
                    not_dotted_quad = 1'b1;
                end else begin
                    if (octet_digits == 2'd0 && c == CH_ZERO) octet_zero_led = 1'b1;
                    octet_value  = sum[7:0];
                    octet_digits = octet_digits + 2'd1;
                end
            end else if (c == CH_DOT) begin
                if (dots_taken == 2'd3 || !octet_complete()) begin
                    not_dotted_quad = 1'b1;
                end else begin
                    done_octets[dots_taken] = octet_value;
                    dots_taken     = dots_taken + 2'd1;
                    octet_value    = 8'd0;
                    octet_digits   = 2'd0;
                    octet_zero_led = 1'b0;
                end
            end else begin
                not_dotted_quad = 1'b1;
            end
        endfunction

        function logic quad_is_local(logic [7:0] a, logic [7:0] b, logic [7:0] c,
                                     logic [7:0] d);
            case (a)
                8'd0:                      return b == 8'd0 && c == 8'd0 && d == 8'd0;
                8'd10, 8'd25, 8'd26, 8'd127: return 1'b1;
                8'd100:                    return b >= 8'd64 && b <= 8'd127;
                8'd169:                    return b == 8'd254;
                8'd172:                    return b >= 8'd16 && b <= 8'd31;
                8'd192:                    return b == 8'd168;
                8'd255:                    return b == 8'd255 && c == 8'd255 && d == 8'd255;
                default:                   return a >= 8'd224 && a <= 8'd239;
            endcase
        endfunction

        // note one accepted word; a last or empty word queues the verdict of its name
        function void take_char(logic [15:0] code, logic last, logic empty);
            logic [15:0] folded;
            logic        is_local;
            logic        suffix_ok;
            t_verdict    v;
            if (empty) begin
                v.allowed = 1'b1;
                v.kind    = KIND_EMPTY;
                pending_verdicts.push_back(v);
                start_name();
                return;
            end
            folded = (code >= CH_UPPER_A && code <= CH_UPPER_Z) ? code + CASE_GAP : code;
            if (seen_count < DOMAIN_LEN) begin
                if (folded != loopback_char(seen_count)) begin
                    host_prefix_ok   = 1'b0;
                    domain_prefix_ok = 1'b0;
                end
                if (seen_count >= NAME_LEN) host_prefix_ok = 1'b0;
            end else begin
                host_prefix_ok   = 1'b0;
                domain_prefix_ok = 1'b0;
            end
            if (seen_count != 5'(POS_TOP)) seen_count = seen_count + 5'd1;
            for (int k = 0; k < SUFFIX_LEN - 1; k++) last_six[k] = last_six[k + 1];
            last_six[SUFFIX_LEN - 1] = folded;
            if (last_six_fill != 3'(SUFFIX_LEN)) last_six_fill = last_six_fill + 3'd1;
            parse_char(code);
            if (!last) return;

            is_local = (host_prefix_ok && seen_count == 5'(NAME_LEN)) ||
                       (domain_prefix_ok && seen_count == 5'(DOMAIN_LEN));
            if (!is_local && last_six_fill == 3'(SUFFIX_LEN)) begin
                suffix_ok = 1'b1;
                for (int k = 0; k < SUFFIX_LEN; k++) begin
                    if (last_six[k] != suffix_char(k)) suffix_ok = 1'b0;
                end
                is_local = suffix_ok;
            end
            if (is_local) begin
                v.allowed = 1'b1;
                v.kind    = KIND_LOCAL;
            end else if (!not_dotted_quad && dots_taken == 2'd3 && octet_complete()) begin
                v.allowed = quad_is_local(done_octets[0], done_octets[1], done_octets[2],
                                          octet_value);
                v.kind    = KIND_IPV4;
            end else begin
                v.allowed = 1'b0;
                v.kind    = KIND_OTHER;
            end
            pending_verdicts.push_back(v);
            start_name();
        endfunction

        function void check_verdict(logic allowed, logic [1:0] kind);
            t_verdict want;
            if (pending_verdicts.size() == 0) begin
                $error("result word with no name waiting: allowed %0d, name_kind %0d",
                       allowed, kind);
                mismatches++;
                return;
            end
            want = pending_verdicts.pop_front();
            if (allowed !== want.allowed) begin
                $error("allowed: expected %0d, actual %0d", want.allowed, allowed);
                mismatches++;
            end
            if (kind !== want.kind) begin
                $error("name_kind: expected %0d, actual %0d", want.kind, kind);
                mismatches++;
            end
        endfunction

        function int pending_count();
            return pending_verdicts.size();
        endfunction
    endclass

endpackage

FILE: tb/tb_top.sv
// testbench top for the local hostname filter: name stimulus, handshake drivers, final verdict
`timescale 1ns / 100ps
module tb_top;
    import hlaf_pkg::*;
    import hostname_verdict_pkg::*;

    localparam int RANDOM_WORDS = 1530;
    localparam int CYCLE_LIMIT  = 400000;
    // extra wait after the final drain, as margin for stray results
    localparam int DRAIN_CYCLES = 8;

    // interesting first and second octets for the allow list boundaries
    localparam int FIRST_COUNT  = 14;
    localparam logic [8*FIRST_COUNT-1:0] FIRST_OCTETS = {
        8'd0, 8'd10, 8'd25, 8'd26, 8'd127, 8'd100, 8'd169,
        8'd172, 8'd192, 8'd224, 8'd239, 8'd240, 8'd255, 8'd223
    };
    localparam int SECOND_COUNT = 14;
    localparam logic [8*SECOND_COUNT-1:0] SECOND_OCTETS = {
        8'd0, 8'd15, 8'd16, 8'd31, 8'd32, 8'd63, 8'd64,
        8'd127, 8'd128, 8'd167, 8'd168, 8'd169, 8'd254, 8'd255
    };
    // codes next to the folding and digit ranges, plus the extremes
    localparam int EDGE_COUNT = 12;
    localparam logic [16*EDGE_COUNT-1:0] EDGE_CODES = {
        16'h0000, 16'hFFFF, 16'h0040, 16'h005B, 16'h0060, 16'h007B,
        16'h002F, 16'h003A, 16'h007F, 16'h0080, 16'h00FF, 16'h0141
    };

    // ways a dotted quad can be spoiled
    typedef enum int {
        QUAD_GOOD,
        QUAD_LEAD_ZERO,
        QUAD_WIDE_OCTET,
        QUAD_THREE,
        QUAD_FIVE,
        QUAD_EMPTY_OCTET,
        QUAD_TRAILING_DOT,
        QUAD_ZERO_RUN,
        QUAD_LETTER
    } t_quad_flaw;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [15:0] i_char_code;
    logic        i_is_last;
    logic        i_empty_name;
    logic        o_out_valid;
    logic        i_out_ready;
    logic        o_allowed;
    logic [1:0]  o_name_kind;

    int          send_idle_pct;
    int          recv_idle_pct;
    int          words_sent  = 0;
    int          cycle_count = 0;
    logic [15:0] name_buf [$];
    hostname_verdict_board names;

    hostname_local_address_filter_unit DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_char_code  (i_char_code),
        .i_is_last    (i_is_last),
        .i_empty_name (i_empty_name),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_allowed    (o_allowed),
        .o_name_kind  (o_name_kind)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // hard stop in case the block hangs or a result never shows up
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // result side: check on handshake, then pick ready for the next edge
    // signals are sampled at the edge before any nonblocking update lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) names.check_verdict(o_allowed, o_name_kind);
            i_out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // one word on the input channel; returns at the edge that takes it
    task automatic send_word(input logic [15:0] code, input logic last, input logic empty);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid   <= 1'b1;
        i_char_code  <= code;
        i_is_last    <= last;
        i_empty_name <= empty;
        do @(posedge i_clk); while (!o_in_ready);
        names.take_char(code, last, empty);
        words_sent++;
    endtask

    // hold the sender off until every queued name has its result
    // it always waits on the clock first, so valid never gets two updates in one step
    task automatic wait_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (names.pending_count() != 0);
    endtask

    function automatic logic [15:0] pick_char();
        logic [15:0] c;
        case ($urandom_range(0, 7))
            0:       c = CH_LOWER_A + 16'($urandom_range(0, 25));
            1:       c = CH_UPPER_A + 16'($urandom_range(0, 25));
            2:       c = CH_ZERO + 16'($urandom_range(0, 9));
            3:       c = CH_DOT;
            4:       c = 16'($urandom());
            5:       c = 16'($urandom_range(0, 127));
            6:       c = 16'($urandom_range(128, 65535));
            default: c = EDGE_CODES[16*$urandom_range(0, EDGE_COUNT - 1) +: 16];
        endcase
        return c;
    endfunction

    // append text, optionally flipping letters to upper case at random
    function automatic void add_text(input string s, input bit mixed);
        logic [15:0] c;
        for (int k = 0; k < s.len(); k++) begin
            c = {8'h00, s[k]};
            if (mixed && c >= CH_LOWER_A && c <= CH_LOWER_Z && $urandom_range(0, 1) == 1)
                c = c - CASE_GAP;
            name_buf.push_back(c);
        end
    endfunction

    function automatic void add_number(input int v, input bit zero_led);
        if (zero_led) add_text("0", 0);
        add_text($sformatf("%0d", v), 0);
    endfunction

    function automatic void add_label();
        int len;
        int r;
        len = $urandom_range(1, 8);
        for (int k = 0; k < len; k++) begin
            r = $urandom_range(0, 9);
            if (r < 6)
                add_text(string'(byte'(CH_LOWER_A + 16'($urandom_range(0, 25)))), 1);
            else if (r < 9)
                name_buf.push_back(CH_ZERO + 16'($urandom_range(0, 9)));
            else
                add_text("-", 0);
        end
    endfunction

    function automatic int pick_tail_octet();
        case ($urandom_range(0, 3))
            0:       return 0;
            1:       return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    // dotted quad aimed at the allow list edges, with at most one flaw
    function automatic void add_quad(input t_quad_flaw flaw);
        int octets [5];
        int count;
        int spot;
        octets[0] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                  : int'(FIRST_OCTETS[8*$urandom_range(0, FIRST_COUNT - 1) +: 8]);
        octets[1] = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 255)
                  : int'(SECOND_OCTETS[8*$urandom_range(0, SECOND_COUNT - 1) +: 8]);
        for (int k = 2; k < 5; k++) octets[k] = pick_tail_octet();
        // all-zero and all-ones addresses
        if ((octets[0] == 0 || octets[0] == 255) && $urandom_range(0, 1) == 1) begin
            for (int k = 1; k < 4; k++) octets[k] = octets[0];
        end
        count = (flaw == QUAD_THREE) ? 3 : (flaw == QUAD_FIVE) ? 5 : 4;
        spot  = $urandom_range(0, count - 1);
        for (int k = 0; k < count; k++) begin
            if (k != 0) add_text(".", 0);
            if (k != spot) begin
                add_number(octets[k], 0);
            end else begin
                case (flaw)
                    QUAD_LEAD_ZERO:   add_number(octets[k], 1);
                    QUAD_WIDE_OCTET:  add_number($urandom_range(256, 999), 0);
                    QUAD_EMPTY_OCTET: ;
                    QUAD_ZERO_RUN: begin
                        add_text("000", 0);
                        add_number(octets[k], 0);
                    end
                    QUAD_LETTER: begin
                        add_number(octets[k], 0);
                        add_text(string'(byte'(CH_LOWER_A + 16'($urandom_range(0, 25)))), 1);
                    end
                    default:          add_number(octets[k], 0);
                endcase
            end
        end
        if (flaw == QUAD_TRAILING_DOT) add_text(".", 0);
    endfunction

    // one random edit so near misses of the known names show up
    function automatic void mutate_name();
        int spot;
        if (name_buf.size() == 0) return;
        spot = $urandom_range(0, name_buf.size() - 1);
        case ($urandom_range(0, 2))
            0:       name_buf[spot] = pick_char();
            1:       void'(name_buf.pop_back());
            default: name_buf.insert(spot, pick_char());
        endcase
    endfunction

    // send the buffered name; an empty buffer goes out as an empty-name word
    task automatic send_name();
        if (name_buf.size() == 0)
            send_word(16'($urandom()), 1'($urandom_range(0, 1)), 1'b1);
        for (int k = 0; k < name_buf.size(); k++)
            send_word(name_buf[k], k == name_buf.size() - 1, 1'b0);
        name_buf.delete();
    endtask

    // buffered characters without a last mark, then an empty word that drops them
    task automatic send_cut_name();
        for (int k = 0; k < name_buf.size(); k++) send_word(name_buf[k], 1'b0, 1'b0);
        name_buf.delete();
        send_word(16'($urandom()), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    task automatic send_text(input string s);
        add_text(s, 0);
        send_name();
    endtask

    task automatic random_name();
        int pick;
        int len;
        bit cut;
        cut  = 1'b0;
        pick = $urandom_range(0, 19);
        if (pick < 2) begin
            // leave the buffer empty: empty-name word
        end else if (pick < 4) begin
            add_text("localhost", 1);
            if ($urandom_range(0, 2) == 0) mutate_name();
        end else if (pick < 6) begin
            add_text("localhost.localdomain", 1);
            if ($urandom_range(0, 2) == 0) mutate_name();
        end else if (pick < 9) begin
            add_label();
            if ($urandom_range(0, 1) == 1) begin
                add_text(".", 0);
                add_label();
            end
            add_text(".local", 1);
            if ($urandom_range(0, 3) == 0) mutate_name();
        end else if (pick < 14) begin
            add_quad(QUAD_GOOD);
            if ($urandom_range(0, 7) == 0) mutate_name();
        end else if (pick < 17) begin
            add_quad(t_quad_flaw'($urandom_range(int'(QUAD_LEAD_ZERO), int'(QUAD_LETTER))));
        end else if (pick < 19) begin
            // noise, mostly short, sometimes past the position counter's top
            len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            for (int k = 0; k < len; k++) name_buf.push_back(pick_char());
        end else begin
            cut = 1'b1;
            if ($urandom_range(0, 1) == 1) add_quad(QUAD_GOOD);
            else add_text("localhost", 1);
            repeat ($urandom_range(0, 2)) void'(name_buf.pop_back());
        end
        if (cut) send_cut_name();
        else send_name();
    endtask

    initial begin
        int phase_end;
        i_rst_n       = 1'b0;
        i_in_valid    = 1'b0;
        i_char_code   = 16'h0000;
        i_is_last     = 1'b0;
        i_empty_name  = 1'b0;
        i_out_ready   = 1'b0;
        send_idle_pct = 34;
        recv_idle_pct = 85;
        names         = new();
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // empty names, with and without the last mark
        send_word(16'hFFFF, 1'b1, 1'b1);
        send_word(16'h0000, 1'b0, 1'b1);
        // exact names, case folding, near misses
        send_text("localhost");
        send_text("LOCALHOST");
        send_text("localhost.localdomain");
        send_text("LocalHost.LocalDomain");
        send_text("localhos");
        send_text("localhostx");
        // suffix: bare, too short, mixed case
        send_text(".local");
        send_text("local");
        send_text("Printer.LOCAL");
        // quads on and off the allow list
        send_text("0.0.0.0");
        send_text("255.255.255.255");
        send_text("25.1.2.3");
        send_text("26.200.0.9");
        send_text("100.64.0.1");
        send_text("100.128.0.1");
        send_text("8.8.8.8");
        send_text("192.168.1.1");
        // malformed quads
        send_text("01.2.3.4");
        send_text("256.1.1.1");
        send_text("1.2.3");
        send_text("1.2.3.4.5");
        send_text("1..2.3");
        send_text("0000.1.1.1");
        // wide code whose low byte is a matching letter must not match
        add_text("localhos", 0);
        name_buf.push_back(16'h0174);
        send_name();
        // code zero after an otherwise good quad
        add_text("10.0.0.1", 0);
        name_buf.push_back(16'h0000);
        send_name();
        // long names: saturated position, suffix still counts; overlong domain fails
        add_text("abcdefghijabcdefghijabcdefghij", 0);
        add_text(".local", 0);
        send_name();
        send_text("localhost.localdomainxxxxxxxxxxxx");

        // random names in three idle settings, fully drained between them
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 34;
                    recv_idle_pct = 85;
                end
                1: begin
                    send_idle_pct = 85;
                    recv_idle_pct = 34;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            phase_end = words_sent + RANDOM_WORDS / 3;
            while (words_sent < phase_end) random_name();
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (names.mismatches == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
